// File: rtl/core/chf_pkg.sv
// types and constants shared by the compass heading pipeline
package chf_pkg;

	// fixed point: field samples carry 8 fraction bits, angles 16 (degrees)
	localparam int FRAC_BITS  = 16;
	localparam int IN_W       = 16;
	localparam int IN_SHIFT   = 8;
	localparam int VEC_W      = 27;
	localparam int ANG_W      = 26;
	localparam int HEAD_W     = 29;
	localparam int WRAP_W     = 31;
	localparam int DECL_W     = 12;
	localparam int OUT_W      = 12;
	localparam int ATAN_N     = 24;
	localparam int ATAN_W     = 22;

	localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(90 * (1 << FRAC_BITS));
	localparam logic signed [WRAP_W-1:0] FULL_TURN   = WRAP_W'(3600 * (1 << FRAC_BITS));

	// atan(2^-i) in degrees, 16 fraction bits, rounded to nearest
	localparam logic [ATAN_W-1:0] ATAN_TABLE [ATAN_N] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
		22'd234379,  22'd117304,  22'd58666,  22'd29335,
		22'd14668,   22'd7334,    22'd3667,   22'd1833,
		22'd917,     22'd458,     22'd229,    22'd115,
		22'd57,      22'd29,      22'd14,     22'd7,
		22'd4,       22'd2,       22'd1,      22'd0
	};

	// vector under rotation with its accumulated angle
	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ANG_W-1:0] z;
		logic                    is_zero;
	} vec_t;

endpackage

// File: rtl/core/chf_cordic_stage.sv
// one registered vectoring step of the arctangent pipeline
module chf_cordic_stage
	import chf_pkg::*;
#(
	parameter int STAGE_IDX = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  vec_t in_vec,
	output logic out_valid,
	input  logic out_ready,
	output vec_t out_vec
);

	localparam logic signed [ANG_W-1:0] ATAN_STEP = ANG_W'(ATAN_TABLE[STAGE_IDX]);

	logic valid_s1;
	vec_t vec_s1;
	vec_t vec_next;
	logic signed [VEC_W-1:0] xs;
	logic signed [VEC_W-1:0] ys;

	assign in_ready = !valid_s1 || out_ready;

	always_comb begin
		xs = in_vec.x >>> STAGE_IDX;
		ys = in_vec.y >>> STAGE_IDX;
		vec_next = in_vec;
		if (in_vec.y > 0) begin
			vec_next.x = in_vec.x + ys;
			vec_next.y = in_vec.y - xs;
			vec_next.z = in_vec.z + ATAN_STEP;
		end else begin
			vec_next.x = in_vec.x - ys;
			vec_next.y = in_vec.y + xs;
			vec_next.z = in_vec.z - ATAN_STEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			vec_s1 <= vec_next;
		end
	end

	assign out_valid = valid_s1;
	assign out_vec   = vec_s1;

endmodule

// File: rtl/core/compass_heading_from_field_core.sv
// top level: magnetometer x/y sample to declination-corrected compass heading
//
// input channel: in_valid/in_ready transfer one sample (field_x, field_y,
// signed 16-bit). output channel: out_valid/out_ready transfer one
// heading_tenths (0 to 3599, tenths of a degree) per sample, in order.
// config channel: cfg_valid/cfg_ready transfer a signed 12-bit declination
// in tenths of a degree; cfg_ready is always high. write it only while the
// pipeline holds no sample.
//
// the pipeline has one stage for the quadrant fold, one per arctangent step,
// one for the declination subtract and one for the wrap into a full turn.
// one sample enters every cycle while the receiver does not stall.
//
// reset empties every stage and loads a declination of 2.1 degrees.
// when the receiver stalls, each stage holds its transfer; stages that hold
// a bubble still move up, so in_ready stays high until every stage is full.
// a zero vector gives a heading of zero before the declination is applied.
module compass_heading_from_field_core
	import chf_pkg::*;
#(
	parameter int ANGLE_ITERATIONS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [IN_W-1:0]   field_x,
	input  logic signed [IN_W-1:0]   field_y,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic        [OUT_W-1:0]  heading_tenths,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic signed [DECL_W-1:0] cfg_data
);

	// the arctangent table stops at 24 entries
	localparam int ITER = (ANGLE_ITERATIONS > ATAN_N) ? ATAN_N : ANGLE_ITERATIONS;

	logic signed [DECL_W-1:0] decl_q;

	// declination register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decl_q <= DECL_W'(21);
		end else if (cfg_valid && cfg_ready) begin
			decl_q <= cfg_data;
		end
	end

	// stage 1: scale and fold the left half plane onto the right
	logic valid_s1;
	vec_t vec_s1;
	vec_t pre_vec;
	logic rdy1;
	logic signed [VEC_W-1:0] xin;
	logic signed [VEC_W-1:0] yin;

	always_comb begin
		xin = VEC_W'(field_x) <<< IN_SHIFT;
		yin = VEC_W'(field_y) <<< IN_SHIFT;
		pre_vec.x       = xin;
		pre_vec.y       = yin;
		pre_vec.z       = '0;
		pre_vec.is_zero = (field_x == '0) && (field_y == '0);
		if (xin < 0) begin
			if (yin >= 0) begin
				// rotate by -90 degrees
				pre_vec.x = yin;
				pre_vec.y = -xin;
				pre_vec.z = QUARTER_TURN;
			end else begin
				// rotate by +90 degrees
				pre_vec.x = -yin;
				pre_vec.y = xin;
				pre_vec.z = -QUARTER_TURN;
			end
		end
	end

	// arctangent steps
	logic valid_chain [ITER+1];
	logic ready_chain [ITER+1];
	vec_t vec_chain   [ITER+1];

	assign valid_chain[0] = valid_s1;
	assign vec_chain[0]   = vec_s1;

	assign rdy1     = !valid_s1 || ready_chain[0];
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			vec_s1 <= pre_vec;
		end
	end

	for (genvar k = 0; k < ITER; k++) begin : g_step
		chf_cordic_stage #(
			.STAGE_IDX (k)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_chain[k]),
			.in_ready  (ready_chain[k]),
			.in_vec    (vec_chain[k]),
			.out_valid (valid_chain[k+1]),
			.out_ready (ready_chain[k+1]),
			.out_vec   (vec_chain[k+1])
		);
	end

	// stage 2: heading in tenths with 16 fraction bits, declination removed
	logic valid_s2;
	logic rdy2;
	logic signed [HEAD_W-1:0] head_s2;
	logic signed [HEAD_W-1:0] ang_ext;
	logic signed [HEAD_W-1:0] decl_ext;
	logic signed [HEAD_W-1:0] head_next;
	vec_t                     last_vec;

	assign last_vec = vec_chain[ITER];

	always_comb begin
		ang_ext   = last_vec.is_zero ? '0 : HEAD_W'(last_vec.z);
		decl_ext  = HEAD_W'(decl_q) <<< FRAC_BITS;
		// times ten as two shifted copies
		head_next = (ang_ext <<< 3) + (ang_ext <<< 1) - decl_ext;
	end

	assign ready_chain[ITER] = rdy2;

	// stage 3: wrap into one full turn
	logic valid_s3;
	logic rdy3;
	logic signed [WRAP_W-1:0] wrap_s3;
	logic signed [WRAP_W-1:0] h_wide;
	logic signed [WRAP_W-1:0] wrap_next;

	assign rdy3 = !valid_s3 || out_ready;
	assign rdy2 = !valid_s2 || rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy2) begin
			valid_s2 <= valid_chain[ITER];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && valid_chain[ITER]) begin
			head_s2 <= head_next;
		end
	end

	// the heading stays within two turns either way, so one of four
	// candidates lands in the turn
	always_comb begin
		h_wide = WRAP_W'(head_s2);
		priority if (h_wide >= FULL_TURN) begin
			wrap_next = h_wide - FULL_TURN;
		end else if (h_wide >= 0) begin
			wrap_next = h_wide;
		end else if (h_wide + FULL_TURN >= 0) begin
			wrap_next = h_wide + FULL_TURN;
		end else begin
			wrap_next = h_wide + (FULL_TURN <<< 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && valid_s2) begin
			wrap_s3 <= wrap_next;
		end
	end

	// drop the fraction bits: truncation of a non-negative value
	assign out_valid      = valid_s3;
	assign heading_tenths = wrap_s3[FRAC_BITS +: OUT_W];

endmodule

// File: tb/heading_check.sv
`timescale 1ns / 1ps
// heading checker: predicts the heading of each accepted field sample and compares the output
module heading_check
	import chf_pkg::*;
#(
	parameter int ANGLE_ITERATIONS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic signed [IN_W-1:0]   field_x,
	input  logic signed [IN_W-1:0]   field_y,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic        [OUT_W-1:0]  heading_tenths,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic signed [DECL_W-1:0] cfg_data,
	output int                       mismatches,
	output int                       pending
);

	localparam int     STEPS           = (ANGLE_ITERATIONS > 24) ? 24 : ANGLE_ITERATIONS;
	localparam longint TURN_TENTHS_Q16 = longint'(3600) << 16;
	localparam longint RIGHT_ANGLE_Q16 = longint'(90) << 16;

	typedef struct {
		logic signed [IN_W-1:0] x;
		logic signed [IN_W-1:0] y;
		logic        [OUT_W-1:0] heading;
	} heading_due_t;

	// atan(2^-i) in degrees, 16 fraction bits
	longint arctan_q16 [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	logic signed [DECL_W-1:0] declination = 12'sd21;
	heading_due_t             headings_due [$];
	heading_due_t             due;
	int                       mismatch_count = 0;
	int                       due_count = 0;

	assign mismatches = mismatch_count;
	assign pending    = due_count;

	function automatic logic [OUT_W-1:0] heading_of_field(logic signed [IN_W-1:0] fx,
			logic signed [IN_W-1:0] fy, logic signed [DECL_W-1:0] decl);
		longint x;
		longint y;
		longint z;
		longint t;
		longint xs;
		longint ys;
		longint h;
		x = fx;
		y = fy;
		z = 0;
		if (x != 0 || y != 0) begin
			x = x * 256;
			y = y * 256;
			// left half plane: turn a quarter first
			if (x < 0) begin
				if (y >= 0) begin
					t = x;
					x = y;
					y = -t;
					z = RIGHT_ANGLE_Q16;
				end else begin
					t = x;
					x = -y;
					y = t;
					z = -RIGHT_ANGLE_Q16;
				end
			end
			for (int i = 0; i < STEPS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y > 0) begin
					x = x + ys;
					y = y - xs;
					z = z + arctan_q16[i];
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - arctan_q16[i];
				end
			end
		end
		h = z * 10 - (longint'(decl) <<< 16);
		h = h % TURN_TENTHS_Q16;
		if (h < 0)
			h = h + TURN_TENTHS_Q16;
		return OUT_W'(h >>> 16);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			declination = 12'sd21;
			headings_due.delete();
			due_count = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				declination = cfg_data;
			if (in_valid && in_ready) begin
				due.x       = field_x;
				due.y       = field_y;
				due.heading = heading_of_field(field_x, field_y, declination);
				headings_due.push_back(due);
			end
			if (out_valid && out_ready) begin
				if (headings_due.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: heading %0d with no sample outstanding", $realtime,
							heading_tenths);
					mismatch_count++;
				end else begin
					due = headings_due.pop_front();
					if (heading_tenths !== due.heading) begin
						if (mismatch_count < 10)
							$display("%0t: field (%0d, %0d) heading expected %0d actual %0d",
								$realtime, due.x, due.y, due.heading, heading_tenths);
						mismatch_count++;
					end
				end
			end
			due_count = headings_due.size();
		end
	end

endmodule

// File: tb/compass_heading_from_field_core_tb.sv
`timescale 1ns / 1ps
// testbench top: drives samples and declination writes into the compass heading core
module compass_heading_from_field_core_tb
	import chf_pkg::*;
();

	localparam int PERIOD       = 8;
	localparam int ITERATIONS   = 16;
	// pipeline depth is iterations plus three; the tail and the pause before a write allow more
	localparam int SETTLE       = ITERATIONS + 3 + 40;
	localparam int PHASE_ITEMS  = 160;
	localparam int HOLD_CYCLES  = 300;
	localparam int LIMIT_CYCLES = 400000;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic signed [IN_W-1:0]   field_x;
	logic signed [IN_W-1:0]   field_y;
	logic                     out_valid;
	logic                     out_ready;
	logic        [OUT_W-1:0]  heading_tenths;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic signed [DECL_W-1:0] cfg_data;

	int mismatches;
	int pending;

	// idling percentages of the current phase
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// long receiver hold-off so that the pipeline fills and in_ready drops
	logic pressure_go = 1'b0;
	logic holding_done = 1'b0;
	logic hold_off;
	assign hold_off = pressure_go && !holding_done;

	// corners: zero vector, axes, full scale, the half turn and near-half-turn points
	int directed_x [20] = '{0, 32767, -32768, 0, 0, 32767, -32768, -32768, 32767, -1,
		-1, -1, 1, 0, 0, 1, -32768, -32768, 100, -21846};
	int directed_y [20] = '{0, 0, 0, 32767, -32768, 32767, -32768, 32767, -32768, 0,
		-1, 1, 0, 1, -1, -1, -1, 1, -1, -21931};

	// declination per phase, extremes of the register among them; the last is drawn at random
	int decl_plan [6] = '{0, 2047, -2048, -1800, 1800, 0};
	int send_plan [6] = '{0, 76, 0, 34, 0, 34};
	int recv_plan [6] = '{0, 0, 76, 34, 0, 34};
	int extreme_vals [5] = '{-32768, -1, 0, 1, 32767};

	int cycles = 0;

	always #(PERIOD / 2) clk = ~clk;

	compass_heading_from_field_core #(
		.ANGLE_ITERATIONS(ITERATIONS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.field_x       (field_x),
		.field_y       (field_y),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.heading_tenths(heading_tenths),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	heading_check #(
		.ANGLE_ITERATIONS(ITERATIONS)
	) i_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.field_x       (field_x),
		.field_y       (field_y),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.heading_tenths(heading_tenths),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	// run guard: a hung handshake ends the run here
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// hold-off counter, started once from the stimulus process
	initial begin
		wait (pressure_go);
		repeat (HOLD_CYCLES) @(posedge clk);
		holding_done = 1'b1;
	end

	// receiver: stalls at random in line with the phase, or for the whole hold-off
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= hold_off ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// one sample transfer; called at a falling edge and returns at one, valid left high
	task automatic offer_sample(input logic signed [IN_W-1:0] sx, input logic signed [IN_W-1:0] sy);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		field_x  <= sx;
		field_y  <= sy;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// lower valid and wait until every heading owed has come back
	task automatic await_drain;
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// declination write while the pipeline is empty
	task automatic write_declination(input logic signed [DECL_W-1:0] decl);
		repeat (SETTLE) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= decl;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic signed [IN_W-1:0] sx;
		logic signed [IN_W-1:0] sy;
		int                     decl;
		in_valid  = 1'b0;
		field_x   = '0;
		field_y   = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed corners at the reset declination of 2.1 degrees
		for (int k = 0; k < 20; k++)
			offer_sample(IN_W'(directed_x[k]), IN_W'(directed_y[k]));

		for (int p = 0; p < 6; p++) begin
			await_drain();
			decl = (p == 5) ? int'($urandom_range(3600)) - 1800 : decl_plan[p];
			write_declination(DECL_W'(decl));
			send_idle_pct  = send_plan[p];
			recv_stall_pct = recv_plan[p];
			// first random phase runs flat out against the long hold-off
			if (p == 0)
				pressure_go <= 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				case ($urandom_range(9))
					5: begin
						// tiny vectors, where truncation in the steps bites hardest
						sx = IN_W'(int'($urandom_range(16)) - 8);
						sy = IN_W'(int'($urandom_range(16)) - 8);
					end
					6: begin
						// on an axis, either sign
						sx = IN_W'($urandom);
						sy = '0;
						if ($urandom_range(1)) begin
							sy = sx;
							sx = '0;
						end
					end
					7: begin
						// diagonals
						sx = IN_W'($urandom);
						sy = $urandom_range(1) ? sx : -sx;
					end
					8: begin
						sx = IN_W'(extreme_vals[$urandom_range(4)]);
						sy = IN_W'(extreme_vals[$urandom_range(4)]);
					end
					9: begin
						// scattered magnitudes
						sx = IN_W'($urandom);
						sy = IN_W'($urandom);
						sx = sx >>> $urandom_range(15);
						sy = sy >>> $urandom_range(15);
					end
					default: begin
						sx = IN_W'($urandom);
						sy = IN_W'($urandom);
					end
				endcase
				offer_sample(sx, sy);
			end
		end

		await_drain();
		// let any stray output show up before the verdict
		repeat (SETTLE) @(negedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/chf_pkg.sv
rtl/core/chf_cordic_stage.sv
rtl/core/compass_heading_from_field_core.sv
tb/heading_check.sv
tb/compass_heading_from_field_core_tb.sv
